// ----- hdl/occc_pkg.sv -----
// ----------------------------------------------------------------------------
// occc_pkg
// Shared types and constants of the odd orbit capture classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package occc_pkg;

   localparam int SEED_W        = 64;
   localparam int MAP_W         = 2;
   localparam int BUDGET_W      = 16;
   localparam int SUM_W         = 24;
   localparam int CID_W         = 2;
   localparam int CSR_INDEX_W   = 8;
   localparam int CSR_DATA_W    = 16;
   localparam int PEAK_LOW_W    = 64;
   localparam int PEAK_HIGH_W   = 36;
   localparam int PEAK_HIGH_LSB = 64;
   localparam int PEAK_EXT_W    = 128;
   localparam int TABLE_IDX_W   = 8;
   localparam int HALVE_STEP    = 8;
   localparam int SHIFT_W       = $clog2(HALVE_STEP + 1);

   localparam logic [CSR_INDEX_W-1:0] REG_MAP_SELECT  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_BUDGET = 8'd1;

   localparam logic [MAP_W-1:0]    MAP_PLUS3    = 2'd0;
   localparam logic [MAP_W-1:0]    MAP_MINUS3   = 2'd1;
   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd512;

   localparam logic [CID_W-1:0] CID_NONE = 2'd0;
   localparam logic [CID_W-1:0] CID_ONE  = 2'd1;
   localparam logic [CID_W-1:0] CID_TWO  = 2'd2;
   localparam logic [CID_W-1:0] CID_THREE = 2'd3;

   typedef enum logic [1:0] {
      FATE_CAPTURED = 2'd0,
      FATE_ESCAPED  = 2'd1,
      FATE_BUDGET   = 2'd2
   } fate_type;

   typedef struct packed {
      logic               load;
      logic               look;
      logic               halve;
      logic               finish;
      fate_type           fate;
      logic [CID_W-1:0]   cid;
   } cmd_type;

   typedef struct packed {
      logic [CID_W-1:0]   cycle_id;
      logic               budget_out;
      logic               zero_minus;
      logic               escape;
      logic               halve_last;
      logic               out_free;
   } status_type;

   // cycle membership for values inside the table window
   function automatic logic [CID_W-1:0] cycle_lookup(input logic [MAP_W-1:0] sel,
                                                     input logic [TABLE_IDX_W-1:0] v);
      logic [CID_W-1:0] c;
      c = CID_NONE;
      case (sel)
         MAP_PLUS3: begin
            if (v == 8'd1) c = CID_ONE;
         end
         MAP_MINUS3: begin
            case (v)
               8'd1: c = CID_ONE;
               8'd5, 8'd7: c = CID_TWO;
               8'd17, 8'd25, 8'd37, 8'd55, 8'd41, 8'd61, 8'd91: c = CID_THREE;
               default: c = CID_NONE;
            endcase
         end
         default: begin
            case (v)
               8'd1, 8'd3: c = CID_ONE;
               8'd13, 8'd33, 8'd83: c = CID_TWO;
               8'd17, 8'd43, 8'd27: c = CID_THREE;
               default: c = CID_NONE;
            endcase
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/occc_channels.sv -----
// ----------------------------------------------------------------------------
// occc channels
// Valid/ready channels for seed words, result words and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface occc_req_if;
   import occc_pkg::*;
   logic              valid;
   logic              ready;
   logic [SEED_W-1:0] seed;
   modport source (output valid, output seed, input ready);
   modport sink   (input valid, input seed, output ready);
endinterface

interface occc_rsp_if;
   import occc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             fate;
   logic [CID_W-1:0]       cycle_id;
   logic [BUDGET_W-1:0]    step_count;
   logic [SUM_W-1:0]       halving_sum;
   logic [PEAK_LOW_W-1:0]  peak_low;
   logic [PEAK_HIGH_W-1:0] peak_high;
   modport source (output valid, output fate, output cycle_id, output step_count,
                   output halving_sum, output peak_low, output peak_high, input ready);
   modport sink   (input valid, input fate, input cycle_id, input step_count,
                   input halving_sum, input peak_low, input peak_high, output ready);
endinterface

interface occc_csr_if;
   import occc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/occc_datapath.sv -----
// ----------------------------------------------------------------------------
// occc_datapath
// Orbit value, product, halving shifter, counters, peak, config and result.
// ----------------------------------------------------------------------------
`default_nettype none

module occc_datapath #(
   parameter int GUARD_BITS       = 100,
   parameter int CYCLE_TABLE_SIZE = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   occc_csr_if.sink                      csr,
   input  logic [occc_pkg::SEED_W-1:0]   seed,
   input  occc_pkg::cmd_type             cmd,
   output occc_pkg::status_type          status,
   occc_rsp_if.source                    rsp
);
   import occc_pkg::*;

   localparam int VW = GUARD_BITS + 3;

   logic [MAP_W-1:0]       map_ff, map_in;
   logic [BUDGET_W-1:0]    budget_ff, budget_in;
   logic [GUARD_BITS-1:0]  x_ff, x_in;
   logic [GUARD_BITS-1:0]  peak_ff, peak_in;
   logic [VW-1:0]          prod_ff, prod_in;
   logic                   esc_ff, esc_in;
   logic [BUDGET_W-1:0]    k_ff, k_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             fate_ff;
   logic [CID_W-1:0]       cid_ff;
   logic [BUDGET_W-1:0]    kout_ff;
   logic [SUM_W-1:0]       sout_ff;
   logic [GUARD_BITS-1:0]  pout_ff;

   logic                   minus;
   logic [VW-1:0]          x_ext, shifted, prod_calc, prod_shift;
   logic [HALVE_STEP-1:0]  low_bits;
   logic [SHIFT_W-1:0]     tz, shift_amt;
   logic                   in_window;
   logic [PEAK_EXT_W-1:0]  peak_ext;

   assign csr.ready = 1'b1;

   always_comb begin
      map_in    = map_ff;
      budget_in = budget_ff;
      if (csr.valid) begin
         if (csr.index == REG_MAP_SELECT)  map_in    = csr.data[MAP_W-1:0];
         if (csr.index == REG_STEP_BUDGET) budget_in = csr.data[BUDGET_W-1:0];
      end
   end

   assign minus     = (map_ff == MAP_MINUS3);
   assign x_ext     = VW'(x_ff);
   assign shifted   = map_ff[1] ? (x_ext << 2) : (x_ext << 1);
   assign prod_calc = minus ? (shifted + x_ext - VW'(1)) : (shifted + x_ext + VW'(1));

   assign low_bits = prod_ff[HALVE_STEP-1:0];

   always_comb begin
      tz = '0;
      for (int i = HALVE_STEP - 1; i >= 0; i--) begin
         if (low_bits[i]) tz = SHIFT_W'(i);
      end
   end

   assign shift_amt  = (low_bits == '0) ? SHIFT_W'(HALVE_STEP) : tz;
   assign prod_shift = prod_ff >> shift_amt;

   assign in_window = (x_ff[GUARD_BITS-1:TABLE_IDX_W] == '0) &&
                      ({1'b0, x_ff[TABLE_IDX_W-1:0]} < (TABLE_IDX_W + 1)'(CYCLE_TABLE_SIZE));

   always_comb begin
      x_in    = x_ff;
      peak_in = peak_ff;
      prod_in = prod_ff;
      esc_in  = esc_ff;
      k_in    = k_ff;
      sum_in  = sum_ff;
      if (cmd.load) begin
         x_in    = GUARD_BITS'(seed);
         peak_in = GUARD_BITS'(seed);
         k_in    = '0;
         sum_in  = '0;
      end else if (cmd.look) begin
         if (x_ff > peak_ff) peak_in = x_ff;
         prod_in = prod_calc;
         esc_in  = (prod_calc[VW-1:GUARD_BITS] != '0);
      end else if (cmd.halve) begin
         prod_in = prod_shift;
         sum_in  = sum_ff + SUM_W'(shift_amt);
         if (low_bits != '0) begin
            x_in = prod_shift[GUARD_BITS-1:0];
            k_in = k_ff + BUDGET_W'(1);
         end
      end
   end

   assign rsp_valid_in = (cmd.finish && status.out_free) ? 1'b1 :
                         (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff       <= MAP_PLUS3;
         budget_ff    <= BUDGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         map_ff       <= map_in;
         budget_ff    <= budget_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      peak_ff <= peak_in;
      prod_ff <= prod_in;
      esc_ff  <= esc_in;
      k_ff    <= k_in;
      sum_ff  <= sum_in;
      if (cmd.finish && status.out_free) begin
         fate_ff <= cmd.fate;
         cid_ff  <= cmd.cid;
         kout_ff <= k_ff;
         sout_ff <= sum_ff;
         pout_ff <= peak_ff;
      end
   end

   always_comb begin
      status.cycle_id   = in_window ? cycle_lookup(map_ff, x_ff[TABLE_IDX_W-1:0]) : CID_NONE;
      status.budget_out = (k_ff >= budget_ff);
      status.zero_minus = minus && (x_ff == '0);
      status.escape     = esc_ff;
      status.halve_last = (low_bits != '0);
      status.out_free   = !rsp_valid_ff || rsp.ready;
   end

   assign peak_ext        = PEAK_EXT_W'(pout_ff);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.fate        = fate_ff;
   assign rsp.cycle_id    = cid_ff;
   assign rsp.step_count  = kout_ff;
   assign rsp.halving_sum = sout_ff;
   assign rsp.peak_low    = peak_ext[PEAK_LOW_W-1:0];
   assign rsp.peak_high   = peak_ext[PEAK_HIGH_LSB+PEAK_HIGH_W-1:PEAK_HIGH_LSB];

endmodule

`default_nettype wire

// ----- hdl/occc_controller.sv -----
// ----------------------------------------------------------------------------
// occc_controller
// Sequencer: seed intake, cycle check, map step, halving passes, result.
// ----------------------------------------------------------------------------
`default_nettype none

module occc_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  occc_pkg::status_type  status,
   output occc_pkg::cmd_type     cmd
);
   import occc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOK   = 4'b0010,
      ST_HALVE  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   fate_type         fate_ff, fate_in;
   logic [CID_W-1:0] cid_ff, cid_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      fate_in    = fate_ff;
      cid_in     = cid_ff;
      cmd        = '0;
      cmd.fate   = fate_ff;
      cmd.cid    = cid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            if (status.cycle_id != CID_NONE) begin
               fate_in  = FATE_CAPTURED;
               cid_in   = status.cycle_id;
               state_in = ST_FINISH;
            end else if (status.budget_out) begin
               fate_in  = FATE_BUDGET;
               cid_in   = CID_NONE;
               state_in = ST_FINISH;
            end else if (status.zero_minus) begin
               fate_in  = FATE_ESCAPED;
               cid_in   = CID_NONE;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_HALVE;
            end
         end
         ST_HALVE: begin
            if (status.escape) begin
               fate_in  = FATE_ESCAPED;
               cid_in   = CID_NONE;
               state_in = ST_FINISH;
            end else begin
               cmd.halve = 1'b1;
               if (status.halve_last) state_in = ST_LOOK;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      fate_ff <= fate_in;
      cid_ff  <= cid_in;
   end

endmodule

`default_nettype wire

// ----- hdl/odd_orbit_capture_classifier.sv -----
// ----------------------------------------------------------------------------
// odd_orbit_capture_classifier
// Iterates an accelerated 3x+1, 3x-1 or 5x+1 map on one odd seed and reports
// capture by a known cycle, escape past the guard width, or budget exhaustion.
// ----------------------------------------------------------------------------
// Per map step the controller runs a check/product state (LOOK) and then
//   halving passes (HALVE) through the single shared shifter; a zero orbit
//   value under 3x-1 is also reported as an escape.
// Throughput: one seed at a time; the next is taken once the result is staged.
// Reset: map_select 0, step_budget 512, no result pending.
`default_nettype none

module odd_orbit_capture_classifier #(
   parameter int GUARD_BITS       = 100,
   parameter int CYCLE_TABLE_SIZE = 128
) (
   input logic        clock,
   input logic        reset,
   occc_req_if.sink   req_ch,
   occc_rsp_if.source rsp_ch,
   occc_csr_if.sink   csr_ch
);
   import occc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_ch.ready = req_ready;

   occc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   occc_datapath #(
      .GUARD_BITS       (GUARD_BITS),
      .CYCLE_TABLE_SIZE (CYCLE_TABLE_SIZE)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr_ch),
      .seed   (req_ch.seed),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb_odd_orbit_capture_classifier.sv -----
// ----------------------------------------------------------------------------
// tb_odd_orbit_capture_classifier
// Self-checking bench for the orbit classifier. A clocked driver takes seed
// words from a backlog queue. An orbit predictor in the bench works out each
// verdict at acceptance, and a clocked monitor checks every result word
// field by field against the oldest pending verdict. The run covers all
// maps, the budget extremes, even and zero seeds, and random seeds of mixed
// size under three idle/stall profiles.
// ----------------------------------------------------------------------------
module tb_odd_orbit_capture_classifier;
   import occc_pkg::*;

   localparam logic [MAP_W-1:0] MAP_PLUS5   = 2'd2;
   localparam logic [MAP_W-1:0] MAP_SPARE   = 2'd3;
   localparam int               ORBIT_GUARD = 100;
   localparam int               CYCLE_WINDOW = 128;

   typedef struct {
      logic [SEED_W-1:0] seed;
      bit                drain;
   } seed_word_type;

   typedef struct {
      fate_type               fate;
      logic [CID_W-1:0]       cycle_id;
      logic [BUDGET_W-1:0]    step_count;
      logic [SUM_W-1:0]       halving_sum;
      logic [PEAK_LOW_W-1:0]  peak_low;
      logic [PEAK_HIGH_W-1:0] peak_high;
   } orbit_verdict_type;

   logic clock;
   logic reset;

   occc_req_if req_if ();
   occc_rsp_if rsp_if ();
   occc_csr_if csr_if ();

   odd_orbit_capture_classifier i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   seed_word_type       seed_backlog[$];
   orbit_verdict_type   pending_verdicts[$];
   logic [MAP_W-1:0]    cfg_map    = MAP_PLUS3;
   logic [BUDGET_W-1:0] cfg_budget = BUDGET_RESET;
   int                  send_idle_pct = 33;
   int                  recv_stall_pct = 50;
   int                  mismatches = 0;
   longint              cycle_count = 0;
   longint              cycle_limit = 20000;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.seed  = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic logic [CID_W-1:0] orbit_cycle(input logic [MAP_W-1:0] sel,
                                                    input logic [127:0] x);
      if (x >= CYCLE_WINDOW) return CID_NONE;
      case (sel)
         MAP_PLUS3: return (x == 1) ? CID_ONE : CID_NONE;
         MAP_MINUS3: begin
            case (x[6:0])
               7'd1: return CID_ONE;
               7'd5, 7'd7: return CID_TWO;
               7'd17, 7'd25, 7'd37, 7'd41, 7'd55, 7'd61, 7'd91: return CID_THREE;
               default: return CID_NONE;
            endcase
         end
         default: begin
            case (x[6:0])
               7'd1, 7'd3: return CID_ONE;
               7'd13, 7'd33, 7'd83: return CID_TWO;
               7'd17, 7'd27, 7'd43: return CID_THREE;
               default: return CID_NONE;
            endcase
         end
      endcase
   endfunction

   function automatic orbit_verdict_type classify_orbit(input logic [SEED_W-1:0] seed,
                                                        input logic [MAP_W-1:0] sel,
                                                        input logic [BUDGET_W-1:0] budget);
      orbit_verdict_type v;
      logic [127:0]     x;
      logic [127:0]     nx;
      logic [127:0]     peak;
      logic [CID_W-1:0] cid;
      logic [SUM_W-1:0] halvings;
      int unsigned      k;
      bit               done;
      x        = {64'd0, seed};
      peak     = x;
      k        = 0;
      halvings = '0;
      v.fate   = FATE_CAPTURED;
      cid      = orbit_cycle(sel, x);
      done     = (cid != CID_NONE);
      while (!done) begin
         if (k >= budget) begin
            v.fate = FATE_BUDGET;
            done   = 1'b1;
         end else if (sel == MAP_MINUS3 && x == 0) begin
            v.fate = FATE_ESCAPED;
            done   = 1'b1;
         end else begin
            if (sel == MAP_MINUS3) nx = 128'd3 * x - 128'd1;
            else if (sel == MAP_PLUS3) nx = 128'd3 * x + 128'd1;
            else nx = 128'd5 * x + 128'd1;
            if (nx[127:ORBIT_GUARD] != 0) begin
               v.fate = FATE_ESCAPED;
               done   = 1'b1;
            end else begin
               while (!nx[0]) begin
                  nx = nx >> 1;
                  halvings = halvings + 1'b1;
               end
               x = nx;
               k++;
               if (x > peak) peak = x;
               cid  = orbit_cycle(sel, x);
               done = (cid != CID_NONE);
            end
         end
      end
      v.cycle_id    = (v.fate == FATE_CAPTURED) ? cid : CID_NONE;
      v.step_count  = k[BUDGET_W-1:0];
      v.halving_sum = halvings;
      v.peak_low    = peak[PEAK_LOW_W-1:0];
      v.peak_high   = peak[PEAK_HIGH_LSB +: PEAK_HIGH_W];
      return v;
   endfunction

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin : seed_driver
      seed_word_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.seed  <= '0;
      end else begin
         if (req_if.valid && req_if.ready)
            pending_verdicts.push_back(classify_orbit(req_if.seed, cfg_map, cfg_budget));
         if (!req_if.valid || req_if.ready) begin
            if (seed_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(seed_backlog[0].drain && pending_verdicts.size() != 0)) begin
               nxt = seed_backlog.pop_front();
               req_if.valid <= 1'b1;
               req_if.seed  <= nxt.seed;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : verdict_monitor
      orbit_verdict_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_verdicts.size() == 0) begin
               $error("result word with no seed outstanding");
               mismatches++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_if.fate !== want.fate) begin
                  $error("fate: expected %0d, got %0d", want.fate, rsp_if.fate);
                  mismatches++;
               end
               if (rsp_if.cycle_id !== want.cycle_id) begin
                  $error("cycle_id: expected %0d, got %0d", want.cycle_id, rsp_if.cycle_id);
                  mismatches++;
               end
               if (rsp_if.step_count !== want.step_count) begin
                  $error("step_count: expected %0d, got %0d",
                         want.step_count, rsp_if.step_count);
                  mismatches++;
               end
               if (rsp_if.halving_sum !== want.halving_sum) begin
                  $error("halving_sum: expected %0d, got %0d",
                         want.halving_sum, rsp_if.halving_sum);
                  mismatches++;
               end
               if (rsp_if.peak_low !== want.peak_low) begin
                  $error("peak_low: expected %h, got %h", want.peak_low, rsp_if.peak_low);
                  mismatches++;
               end
               if (rsp_if.peak_high !== want.peak_high) begin
                  $error("peak_high: expected %h, got %h", want.peak_high, rsp_if.peak_high);
                  mismatches++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic settle();
      while (seed_backlog.size() != 0 || req_if.valid || pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         REG_MAP_SELECT:  cfg_map = val[MAP_W-1:0];
         REG_STEP_BUDGET: cfg_budget = val;
         default: ;
      endcase
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_config(input logic [MAP_W-1:0] sel, input logic [BUDGET_W-1:0] budget);
      logic [CSR_DATA_W-1:0] word;
      settle();
      word = $urandom;
      word[MAP_W-1:0] = sel;
      write_reg(REG_MAP_SELECT, word);
      write_reg(REG_STEP_BUDGET, budget);
   endtask

   task automatic queue_seed(input logic [SEED_W-1:0] s, input bit drain = 1'b0);
      seed_word_type w;
      w.seed  = s;
      w.drain = drain;
      seed_backlog.push_back(w);
      // worst step: a check/product pass, then the shift passes
      cycle_limit += 4 * (longint'(cfg_budget) * 16 + 200);
   endtask

   function automatic logic [SEED_W-1:0] pick_seed();
      logic [SEED_W-1:0] s;
      int unsigned       kind;
      kind = $urandom_range(0, 19);
      s    = {$urandom, $urandom};
      if (kind < 8) s = s & 64'hFFFF;
      else if (kind < 14) s = s & 64'hFFFF_FFFF;
      if (kind != 19) s[0] = 1'b1;
      return s;
   endfunction

   task automatic random_phase(input logic [MAP_W-1:0] sel, input logic [BUDGET_W-1:0] budget,
                               input int count, input int pause_at = -1);
      set_config(sel, budget);
      for (int i = 0; i < count; i++)
         queue_seed(pick_seed(), i == pause_at);
   endtask

   initial begin
      reset = 1'b1;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: 3x+1, budget 512
      queue_seed(64'd1);
      queue_seed(64'd3);
      queue_seed(64'd27);
      queue_seed(64'd0);
      queue_seed(64'd2);
      queue_seed(64'hFFFF_FFFF_FFFF_FFFF);
      queue_seed(64'h8000_0000_0000_0001);
      queue_seed(64'd129);

      set_config(MAP_MINUS3, BUDGET_RESET);
      queue_seed(64'd0);
      queue_seed(64'd5);
      queue_seed(64'd91);
      queue_seed(64'd61);
      queue_seed(64'd3);
      queue_seed(64'hFFFF_FFFF_FFFF_FFFF);
      queue_seed(64'd6);

      // unused selector behaves as 5x+1
      set_config(MAP_SPARE, BUDGET_RESET);
      queue_seed(64'd3);
      queue_seed(64'd83);
      queue_seed(64'd43);
      queue_seed(64'd5);
      queue_seed(64'hFFFF_FFFF_FFFF_FFFF);
      queue_seed(64'd127);

      set_config(MAP_PLUS5, 16'd0);
      queue_seed(64'd27);
      queue_seed(64'd7);
      queue_seed(64'd0);

      set_config(MAP_MINUS3, 16'd0);
      queue_seed(64'd0);

      random_phase(MAP_PLUS3, BUDGET_RESET, 350, 120);
      random_phase(MAP_MINUS3, 16'd600, 300);

      settle();
      send_idle_pct  = 50;
      recv_stall_pct = 33;
      random_phase(MAP_PLUS5, BUDGET_RESET, 250);
      random_phase(MAP_SPARE, 16'd37, 200, 50);
      random_phase(MAP_PLUS3, 16'hFFFF, 20);

      settle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_phase(MAP_MINUS3, 16'd300, 400);
      random_phase(MAP_PLUS5, 16'd1, 150);
      random_phase(MAP_PLUS3, 16'd200, 300);

      settle();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
